/* sv/tksq_pkg.sv */
// shared types and constants of the two-key sorted priority queue
package tksq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 16;
    localparam int KEY2_BITS_DEF = 8 + 8;
    localparam int TAG_BITS_DEF  = 8;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command shared by every cell of the chain
    typedef struct packed {
        logic ins;
        logic ext;
    } t_cell_ctrl;

endpackage

/* sv/tksq_if.sv */
// request and response channel interfaces of the sorted priority queue
interface tksq_req_if #(
    parameter int PRIO_W = tksq_pkg::PRIO_BITS_DEF,
    parameter int KEY2_W = tksq_pkg::KEY2_BITS_DEF,
    parameter int TAG_W  = tksq_pkg::TAG_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic              mode;
    logic [PRIO_W-1:0] priority_req;
    logic [KEY2_W-1:0] secondary_key;
    logic [TAG_W-1:0]  tag;

    modport source (output valid, mode, priority_req, secondary_key, tag, input ready);
    modport sink   (input valid, mode, priority_req, secondary_key, tag, output ready);
endinterface

interface tksq_rsp_if #(
    parameter int PRIO_W = tksq_pkg::PRIO_BITS_DEF,
    parameter int KEY2_W = tksq_pkg::KEY2_BITS_DEF,
    parameter int TAG_W  = tksq_pkg::TAG_BITS_DEF,
    parameter int OCC_W  = $clog2(tksq_pkg::DEPTH_DEF + 1)
);
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PRIO_W-1:0] out_priority;
    logic [KEY2_W-1:0] out_secondary_key;
    logic [TAG_W-1:0]  out_tag;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, status, out_priority, out_secondary_key, out_tag,
                    occupancy, input ready);
    modport sink   (input valid, status, out_priority, out_secondary_key, out_tag,
                    occupancy, output ready);
endinterface

/* sv/two_key_sorted_priority_queue.sv */
// top level of the two-key sorted priority queue built from a chain of cells
//
//  channel | dir | handshake           | payload
//  i_req   | in  | i_req.valid/ready   | mode, priority_req, secondary_key, tag
//  o_rsp   | out | o_rsp.valid/ready   | status, out_priority, out_secondary_key,
//          |     |                     | out_tag, occupancy
//
// one request per cycle while i_req.ready is high; its response is registered and shows in the next cycle
// every cell compares against the new entry at once, so the chain shifts in one step
// i_req.ready falls only while a response waits and o_rsp.ready is low
// reset clears the entry count and the response valid; cell contents are not cleared
module two_key_sorted_priority_queue #(
    parameter int DEPTH     = tksq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = tksq_pkg::PRIO_BITS_DEF,
    parameter int KEY2_BITS = tksq_pkg::KEY2_BITS_DEF,
    parameter int TAG_BITS  = tksq_pkg::TAG_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    tksq_req_if.sink   i_req,
    tksq_rsp_if.source o_rsp
);
    localparam int ENTRY_W = PRIO_BITS + KEY2_BITS + TAG_BITS;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    tksq_pkg::t_status    r_status;
    tksq_pkg::t_status    n_status;
    logic [PRIO_BITS-1:0] r_out_prio;
    logic [PRIO_BITS-1:0] n_out_prio;
    logic [KEY2_BITS-1:0] r_out_key2;
    logic [KEY2_BITS-1:0] n_out_key2;
    logic [TAG_BITS-1:0]  r_out_tag;
    logic [TAG_BITS-1:0]  n_out_tag;

    logic                 req_acc;
    logic                 full;
    logic                 empty;
    tksq_pkg::t_cell_ctrl ctrl;
    logic [ENTRY_W-1:0]   new_entry;
    logic [ENTRY_W-1:0]   cell_entry [DEPTH];
    logic                 cell_after [DEPTH];
    logic                 cell_valid [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_acc     = i_req.valid && i_req.ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);
    assign new_entry   = {i_req.priority_req, i_req.secondary_key, i_req.tag};

    always_comb begin
        ctrl.ins = req_acc && (i_req.mode == tksq_pkg::MODE_INSERT) && !full;
        ctrl.ext = req_acc && (i_req.mode == tksq_pkg::MODE_EXTRACT) && !empty;
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [ENTRY_W-1:0] left_entry;
        logic               left_after;
        logic [ENTRY_W-1:0] right_entry;

        assign cell_valid[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign left_entry = new_entry;
            assign left_after = 1'b0;
        end else begin : g_body
            assign left_entry = cell_entry[gi-1];
            assign left_after = cell_after[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_mid
            assign right_entry = cell_entry[gi+1];
        end

        tksq_cell #(
            .PRIO_W (PRIO_BITS),
            .KEY2_W (KEY2_BITS),
            .TAG_W  (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_valid       (cell_valid[gi]),
            .i_new_entry   (new_entry),
            .i_left_entry  (left_entry),
            .i_left_after  (left_after),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[gi]),
            .o_after       (cell_after[gi])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out_prio  = r_out_prio;
        n_out_key2  = r_out_key2;
        n_out_tag   = r_out_tag;
        if (req_acc) begin
            n_out_valid = 1'b1;
            n_status    = tksq_pkg::ST_OK;
            n_out_prio  = '0;
            n_out_key2  = '0;
            n_out_tag   = '0;
            if (i_req.mode == tksq_pkg::MODE_INSERT) begin
                if (full) begin
                    n_status = tksq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (empty) begin
                    n_status = tksq_pkg::ST_EMPTY;
                end else begin
                    n_count    = r_count - CNT_W'(1);
                    n_out_prio = cell_entry[0][ENTRY_W-1 -: PRIO_BITS];
                    n_out_key2 = cell_entry[0][TAG_BITS +: KEY2_BITS];
                    n_out_tag  = cell_entry[0][TAG_BITS-1:0];
                end
            end
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_out_prio <= n_out_prio;
        r_out_key2 <= n_out_key2;
        r_out_tag  <= n_out_tag;
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_status;
    assign o_rsp.out_priority      = r_out_prio;
    assign o_rsp.out_secondary_key = r_out_key2;
    assign o_rsp.out_tag           = r_out_tag;
    assign o_rsp.occupancy         = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (i_req.mode == tksq_pkg::MODE_INSERT) && full)
        |=> (r_status == tksq_pkg::ST_FULL) && $stable(r_count))
        else $error("insert into full queue not dropped");

    a_extract_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ext |=> (r_out_prio == $past(cell_entry[0][ENTRY_W-1 -: PRIO_BITS]))
                     && (r_count == $past(r_count) - CNT_W'(1)))
        else $error("extract did not return the head entry");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_out_valid)
        else $error("request stalled with no response pending");

    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.ins && ctrl.ext))
        else $error("insert and extract in the same cycle");

endmodule

/* sv/tksq_cell.sv */
// one slot of the sorted chain: compares against the new entry and shifts
module tksq_cell #(
    parameter int PRIO_W = tksq_pkg::PRIO_BITS_DEF,
    parameter int KEY2_W = tksq_pkg::KEY2_BITS_DEF,
    parameter int TAG_W  = tksq_pkg::TAG_BITS_DEF
) (
    input  logic                            i_clk,
    input  tksq_pkg::t_cell_ctrl            i_ctrl,
    input  logic                            i_valid,
    input  logic [PRIO_W+KEY2_W+TAG_W-1:0]  i_new_entry,
    input  logic [PRIO_W+KEY2_W+TAG_W-1:0]  i_left_entry,
    input  logic                            i_left_after,
    input  logic [PRIO_W+KEY2_W+TAG_W-1:0]  i_right_entry,
    output logic [PRIO_W+KEY2_W+TAG_W-1:0]  o_entry,
    output logic                            o_after
);
    localparam int ENTRY_W = PRIO_W + KEY2_W + TAG_W;

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;
    logic [PRIO_W-1:0]  my_prio;
    logic [PRIO_W-1:0]  new_prio;
    logic [KEY2_W-1:0]  my_key2;
    logic [KEY2_W-1:0]  new_key2;

    assign my_prio  = r_entry[ENTRY_W-1 -: PRIO_W];
    assign new_prio = i_new_entry[ENTRY_W-1 -: PRIO_W];
    assign my_key2  = r_entry[TAG_W +: KEY2_W];
    assign new_key2 = i_new_entry[TAG_W +: KEY2_W];

    // empty slots sort behind everything, equal keys stay ahead of the newcomer
    always_comb begin
        o_after = !i_valid || (my_prio > new_prio)
                  || ((my_prio == new_prio) && (my_key2 > new_key2));
    end

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.ext) begin
            n_entry = i_right_entry;
        end else if (i_ctrl.ins && o_after) begin
            n_entry = i_left_after ? i_left_entry : i_new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins || i_ctrl.ext) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the two-key sorted priority queue with its own queue predictor
module tb;

    localparam int Q_DEPTH     = tksq_pkg::DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        tksq_pkg::t_status status;
        logic [15:0]       prio;
        logic [15:0]       key2;
        logic [7:0]        tag;
        logic [4:0]        occ;
    } t_rsp_item;

    logic i_clk;
    logic i_rst_n;

    tksq_req_if req_if ();
    tksq_rsp_if rsp_if ();

    two_key_sorted_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predicted queue contents, head at index 0
    logic [15:0] held_prio [Q_DEPTH];
    logic [15:0] held_key2 [Q_DEPTH];
    logic [7:0]  held_tag  [Q_DEPTH];
    int          held_count = 0;

    t_rsp_item pending_rsp_q [$];

    int error_count  = 0;
    int stall_cycles = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_req  = 0;
    int rx_hold_left = 0;

    always #6 i_clk = ~i_clk;

    function automatic void predict_request(input logic mode, input logic [15:0] prio,
                                            input logic [15:0] key2, input logic [7:0] tag);
        t_rsp_item rsp;
        int        pos;
        rsp = '{tksq_pkg::ST_OK, 16'h0, 16'h0, 8'h0, 5'd0};
        if (mode == tksq_pkg::MODE_INSERT) begin
            if (held_count >= Q_DEPTH) begin
                rsp.status = tksq_pkg::ST_FULL;
            end else begin
                // new entry goes behind every entry with an equal key pair
                pos = held_count;
                for (int i = 0; i < held_count; i++) begin
                    if (pos == held_count &&
                        (held_prio[i] > prio || (held_prio[i] == prio && held_key2[i] > key2)))
                        pos = i;
                end
                for (int i = held_count; i > pos; i--) begin
                    held_prio[i] = held_prio[i-1];
                    held_key2[i] = held_key2[i-1];
                    held_tag[i]  = held_tag[i-1];
                end
                held_prio[pos] = prio;
                held_key2[pos] = key2;
                held_tag[pos]  = tag;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                rsp.status = tksq_pkg::ST_EMPTY;
            end else begin
                rsp.prio = held_prio[0];
                rsp.key2 = held_key2[0];
                rsp.tag  = held_tag[0];
                for (int i = 1; i < held_count; i++) begin
                    held_prio[i-1] = held_prio[i];
                    held_key2[i-1] = held_key2[i];
                    held_tag[i-1]  = held_tag[i];
                end
                held_count--;
            end
        end
        rsp.occ = held_count[4:0];
        pending_rsp_q.push_back(rsp);
    endfunction

    function automatic void check_response(input t_rsp_item got);
        t_rsp_item want;
        if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d",
                     $time, got.status);
            error_count++;
        end else begin
            want = pending_rsp_q.pop_front();
            if (got.status != want.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got.status);
                error_count++;
            end
            if (got.prio != want.prio) begin
                $display("%0t: out_priority mismatch, expected %h actual %h",
                         $time, want.prio, got.prio);
                error_count++;
            end
            if (got.key2 != want.key2) begin
                $display("%0t: out_secondary_key mismatch, expected %h actual %h",
                         $time, want.key2, got.key2);
                error_count++;
            end
            if (got.tag != want.tag) begin
                $display("%0t: out_tag mismatch, expected %h actual %h",
                         $time, want.tag, got.tag);
                error_count++;
            end
            if (got.occ != want.occ) begin
                $display("%0t: occupancy mismatch, expected %0d actual %0d",
                         $time, want.occ, got.occ);
                error_count++;
            end
        end
    endfunction

    // request side is handled first so a same-edge response would still find its entry
    always @(posedge i_clk) begin
        t_rsp_item got;
        if (i_rst_n && req_if.valid && req_if.ready)
            predict_request(req_if.mode, req_if.priority_req, req_if.secondary_key, req_if.tag);
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status = tksq_pkg::t_status'(rsp_if.status);
            got.prio   = rsp_if.out_priority;
            got.key2   = rsp_if.out_secondary_key;
            got.tag    = rsp_if.out_tag;
            got.occ    = rsp_if.occupancy;
            check_response(got);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // response side back-pressure, with an optional long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_request(input logic mode, input logic [15:0] prio,
                                input logic [15:0] key2, input logic [7:0] tag);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.mode          <= mode;
        req_if.priority_req  <= prio;
        req_if.secondary_key <= key2;
        req_if.tag           <= tag;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    // extract payload is don't-care, so it is always random
    task automatic send_extract();
        send_request(tksq_pkg::MODE_EXTRACT, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    function automatic logic [15:0] pick_key(input int spread);
        case (spread)
            0: return 16'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_empty_extract();
        send_extract();
    endtask

    task automatic test_field_extremes();
        send_request(tksq_pkg::MODE_INSERT, 16'hffff, 16'hffff, 8'hff);
        send_request(tksq_pkg::MODE_INSERT, 16'h0000, 16'hffff, 8'h5a);
        send_request(tksq_pkg::MODE_INSERT, 16'hffff, 16'h0000, 8'ha5);
        send_request(tksq_pkg::MODE_INSERT, 16'h0000, 16'h0000, 8'h00);
    endtask

    // ties at the head and at the tail must leave in arrival order
    task automatic test_equal_keys();
        send_request(tksq_pkg::MODE_INSERT, 16'h0000, 16'h0000, 8'h01);
        send_request(tksq_pkg::MODE_INSERT, 16'h0000, 16'h0000, 8'h02);
        send_request(tksq_pkg::MODE_INSERT, 16'h0000, 16'h0000, 8'h03);
        send_request(tksq_pkg::MODE_INSERT, 16'hffff, 16'hffff, 8'h11);
        repeat (4) send_extract();
    endtask

    // four entries are left from the tie test
    task automatic test_fill_overflow();
        repeat (Q_DEPTH - 4)
            send_request(tksq_pkg::MODE_INSERT, pick_key(2), pick_key(0), 8'($urandom));
        send_request(tksq_pkg::MODE_INSERT, 16'h1234, 16'h5678, 8'h9a);
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int insert_pct;
        int spread;
        int burst_left;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        insert_pct  = 50;
        spread      = 0;
        burst_left  = 0;
        for (int n = 0; n < n_items; n++) begin
            // bursts biased toward filling or draining reach both full and empty often
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 48);
                spread     = $urandom_range(0, 2);
                case ($urandom_range(0, 3))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    2: insert_pct = 80;
                    default: insert_pct = 95;
                endcase
            end
            burst_left--;
            if ($urandom_range(0, 99) < insert_pct)
                send_request(tksq_pkg::MODE_INSERT, pick_key(spread), pick_key(spread),
                             8'($urandom));
            else
                send_extract();
        end
    endtask

    // receiver stalls long while requests keep coming
    task automatic test_receiver_hold();
        rx_hold_req = 300;
        for (int n = 0; n < 24; n++) begin
            if (n % 4 == 3)
                send_extract();
            else
                send_request(tksq_pkg::MODE_INSERT, pick_key(0), pick_key(2), 8'($urandom));
        end
    endtask

    task automatic test_sender_pause();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (4) send_request(tksq_pkg::MODE_INSERT, pick_key(2), pick_key(2), 8'($urandom));
        repeat (4) send_extract();
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.mode          = tksq_pkg::MODE_INSERT;
        req_if.priority_req  = '0;
        req_if.secondary_key = '0;
        req_if.tag           = '0;
        rsp_if.ready         = 1'b0;
        tx_idle_pct          = 35;
        rx_idle_pct          = 49;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_extract();
        test_field_extremes();
        test_equal_keys();
        test_fill_overflow();
        test_random_traffic(620, 35, 49);
        test_receiver_hold();
        test_random_traffic(620, 49, 35);
        test_sender_pause();
        test_random_traffic(620, 0, 0);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
